/* rtl/smt_pkg.sv */
// ----------------------------------------------------------------------------
// smt_pkg
// shared constants and types for the sector multiplicity trigger
// ----------------------------------------------------------------------------
package smt_pkg;

    localparam int NUM_SECTORS = 6;
    localparam int CNT_BITS    = 10;
    localparam int EVT_BITS    = 32;
    localparam int CFG_IDX_W   = 3;

    localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};

    // item modes
    localparam logic [1:0] MODE_OUTER = 2'd0;
    localparam logic [1:0] MODE_INNER = 2'd1;
    localparam logic [1:0] MODE_EOE   = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TOTAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INNER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_OUTER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEED_OPP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIM_MODE  = 3'd4;

    typedef struct packed {
        logic [CNT_BITS-1:0]    outer_total;
        logic [CNT_BITS-1:0]    inner_total;
        logic [NUM_SECTORS-1:0] sec_active;
    } t_evt;

    typedef struct packed {
        logic [CNT_BITS-1:0] min_total;
        logic [CNT_BITS-1:0] min_inner;
        logic [CNT_BITS-1:0] min_outer;
        logic                need_opp;
        logic                sim_mode;
    } t_cfg;

endpackage

/* rtl/sector_multiplicity_trigger_unit.sv */
// ----------------------------------------------------------------------------
// sector_multiplicity_trigger_unit
// first-level trigger for a six-sector detector. Hit transactions and
// end-of-event transactions are taken one per clock cycle: hits update the
// per-event counters in the cycle they are accepted, and an end-of-event
// transaction is evaluated in that same cycle into the result register, whose
// result is visible in the next cycle. Input ready drops only for an
// end-of-event transaction while the previous result is held and not being
// taken; hit transactions are accepted every cycle regardless.
// ----------------------------------------------------------------------------
module sector_multiplicity_trigger_unit
    import smt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CNT_BITS-1:0]  i_cfg_data,

    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_mode,
    input  logic [2:0]           i_sector,
    input  logic                 i_left_time_pos,
    input  logic                 i_right_time_pos,
    input  logic                 i_inner_time_pos,

    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_skip_event,
    output logic [CNT_BITS:0]    o_total_mult,
    output logic [CNT_BITS-2:0]  o_outer_mult,
    output logic [CNT_BITS-1:0]  o_inner_mult,
    output logic                 o_opposite_found,
    output logic [EVT_BITS-1:0]  o_events_seen,
    output logic [EVT_BITS-1:0]  o_events_rejected
);

    t_cfg r_cfg;
    t_evt evt;
    logic in_acc;
    logic eoe_acc;
    logic out_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_TOTAL: r_cfg.min_total <= i_cfg_data;
                CFG_MIN_INNER: r_cfg.min_inner <= i_cfg_data;
                CFG_MIN_OUTER: r_cfg.min_outer <= i_cfg_data;
                CFG_NEED_OPP:  r_cfg.need_opp  <= i_cfg_data[0];
                CFG_SIM_MODE:  r_cfg.sim_mode  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign out_take   = o_out_valid & i_out_ready;
    assign o_in_ready = (i_mode != MODE_EOE) | ~o_out_valid | i_out_ready;
    assign in_acc     = i_in_valid & o_in_ready;
    assign eoe_acc    = in_acc & (i_mode == MODE_EOE);

    smt_accum u_accum (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (in_acc),
        .i_mode           (i_mode),
        .i_sector         (i_sector),
        .i_left_time_pos  (i_left_time_pos),
        .i_right_time_pos (i_right_time_pos),
        .i_inner_time_pos (i_inner_time_pos),
        .i_sim_mode       (r_cfg.sim_mode),
        .o_evt            (evt)
    );

    smt_eval u_eval (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_load            (eoe_acc),
        .i_take            (out_take),
        .i_evt             (evt),
        .i_cfg             (r_cfg),
        .o_valid           (o_out_valid),
        .o_skip_event      (o_skip_event),
        .o_total_mult      (o_total_mult),
        .o_outer_mult      (o_outer_mult),
        .o_inner_mult      (o_inner_mult),
        .o_opposite_found  (o_opposite_found),
        .o_events_seen     (o_events_seen),
        .o_events_rejected (o_events_rejected)
    );

`ifndef SYNTHESIS
    // end of event always produces a result next cycle
    a_eoe_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eoe_acc |=> o_out_valid)
        else $error("end of event without result");

    // counters advance once per evaluated event
    a_seen_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eoe_acc |=> (o_events_seen == $past(o_events_seen) + 32'd1))
        else $error("event counter step wrong");

    // rejected counter follows the skip decision
    a_rej_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eoe_acc |=> (o_events_rejected == $past(o_events_rejected)
                     + {31'd0, o_skip_event}))
        else $error("rejected counter mismatch");

    // total is the sum of the parts
    a_total_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_total_mult == {2'b00, o_outer_mult} + {1'b0, o_inner_mult}))
        else $error("total multiplicity mismatch");
`endif

endmodule

/* rtl/smt_accum.sv */
// ----------------------------------------------------------------------------
// smt_accum
// per-event hit accumulation: sector end counts, inner flags and totals
// ----------------------------------------------------------------------------
module smt_accum
    import smt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [1:0] i_mode,
    input  logic [2:0] i_sector,
    input  logic       i_left_time_pos,
    input  logic       i_right_time_pos,
    input  logic       i_inner_time_pos,
    input  logic       i_sim_mode,
    output t_evt       o_evt
);

    logic [1:0]          r_ends [NUM_SECTORS];
    logic [1:0]          n_ends [NUM_SECTORS];
    logic [NUM_SECTORS-1:0] r_inner, n_inner;
    logic [CNT_BITS-1:0] r_outer_tot, n_outer_tot;
    logic [CNT_BITS-1:0] r_inner_tot, n_inner_tot;

    logic [1:0]          ends_inc;
    logic [2:0]          sec_sum [NUM_SECTORS];
    logic [CNT_BITS:0]   outer_sum;
    logic [CNT_BITS:0]   inner_sum;
    logic                inner_ok;

    assign ends_inc  = {1'b0, i_left_time_pos} + {1'b0, i_right_time_pos};
    assign outer_sum = {1'b0, r_outer_tot} + {{(CNT_BITS-1){1'b0}}, ends_inc};
    assign inner_sum = {1'b0, r_inner_tot} + {{CNT_BITS{1'b0}}, 1'b1};
    assign inner_ok  = i_sim_mode | i_inner_time_pos;

    always_comb begin
        for (int s = 0; s < NUM_SECTORS; s++) begin
            sec_sum[s] = {1'b0, r_ends[s]} + {1'b0, ends_inc};
            n_ends[s]  = r_ends[s];
        end
        n_inner     = r_inner;
        n_outer_tot = r_outer_tot;
        n_inner_tot = r_inner_tot;
        if (i_accept) begin
            case (i_mode)
                MODE_OUTER: begin
                    for (int s = 0; s < NUM_SECTORS; s++) begin
                        if (i_sector == 3'(s)) begin
                            n_ends[s] = (sec_sum[s] > 3'd2) ? 2'd2 : sec_sum[s][1:0];
                        end
                    end
                    n_outer_tot = outer_sum[CNT_BITS] ? CNT_MAX : outer_sum[CNT_BITS-1:0];
                end
                MODE_INNER: begin
                    if (inner_ok) begin
                        for (int s = 0; s < NUM_SECTORS; s++) begin
                            if (i_sector == 3'(s)) begin
                                n_inner[s] = 1'b1;
                            end
                        end
                        n_inner_tot = inner_sum[CNT_BITS] ? CNT_MAX
                                                          : inner_sum[CNT_BITS-1:0];
                    end
                end
                MODE_EOE: begin
                    for (int s = 0; s < NUM_SECTORS; s++) begin
                        n_ends[s] = 2'd0;
                    end
                    n_inner     = '0;
                    n_outer_tot = '0;
                    n_inner_tot = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SECTORS; s++) begin
                r_ends[s] <= 2'd0;
            end
            r_inner     <= '0;
            r_outer_tot <= '0;
            r_inner_tot <= '0;
        end else begin
            r_ends      <= n_ends;
            r_inner     <= n_inner;
            r_outer_tot <= n_outer_tot;
            r_inner_tot <= n_inner_tot;
        end
    end

    always_comb begin
        o_evt.outer_total = r_outer_tot;
        o_evt.inner_total = r_inner_tot;
        for (int s = 0; s < NUM_SECTORS; s++) begin
            o_evt.sec_active[s] = (r_ends[s] == 2'd2) | r_inner[s];
        end
    end

endmodule

/* rtl/smt_eval.sv */
// ----------------------------------------------------------------------------
// smt_eval
// end-of-event trigger decision, event counters and result register
// ----------------------------------------------------------------------------
module smt_eval
    import smt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic                i_take,
    input  t_evt                i_evt,
    input  t_cfg                i_cfg,
    output logic                o_valid,
    output logic                o_skip_event,
    output logic [CNT_BITS:0]   o_total_mult,
    output logic [CNT_BITS-2:0] o_outer_mult,
    output logic [CNT_BITS-1:0] o_inner_mult,
    output logic                o_opposite_found,
    output logic [EVT_BITS-1:0] o_events_seen,
    output logic [EVT_BITS-1:0] o_events_rejected
);

    localparam int HALF = NUM_SECTORS / 2;

    logic [CNT_BITS-2:0] omult;
    logic [CNT_BITS:0]   tmult;
    logic                opp;
    logic                skip;

    logic                r_valid;
    logic                r_skip;
    logic [CNT_BITS:0]   r_total;
    logic [CNT_BITS-2:0] r_outer;
    logic [CNT_BITS-1:0] r_inner;
    logic                r_opp;
    logic [EVT_BITS-1:0] r_seen;
    logic [EVT_BITS-1:0] r_rej;

    assign omult = i_evt.outer_total[CNT_BITS-1:1];
    assign tmult = {2'b00, omult} + {1'b0, i_evt.inner_total};

    always_comb begin
        opp = 1'b0;
        for (int s = 0; s < HALF; s++) begin
            opp = opp | (i_evt.sec_active[s] & i_evt.sec_active[s+HALF]);
        end
    end

    assign skip = (tmult < {1'b0, i_cfg.min_total})
                | (i_evt.inner_total < i_cfg.min_inner)
                | ({1'b0, omult} < i_cfg.min_outer)
                | (i_cfg.need_opp & ~opp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_seen  <= '0;
            r_rej   <= '0;
        end else begin
            if (i_load) begin
                r_valid <= 1'b1;
                r_seen  <= r_seen + {{(EVT_BITS-1){1'b0}}, 1'b1};
                r_rej   <= r_rej + {{(EVT_BITS-1){1'b0}}, skip};
            end else if (i_take) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_skip  <= skip;
            r_total <= tmult;
            r_outer <= omult;
            r_inner <= i_evt.inner_total;
            r_opp   <= opp;
        end
    end

    assign o_valid           = r_valid;
    assign o_skip_event      = r_skip;
    assign o_total_mult      = r_total;
    assign o_outer_mult      = r_outer;
    assign o_inner_mult      = r_inner;
    assign o_opposite_found  = r_opp;
    assign o_events_seen     = r_seen;
    assign o_events_rejected = r_rej;

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for sector_multiplicity_trigger_unit. Hit and
// end-of-event transactions go in with random bursts and gaps while the
// result side stalls on its own pattern. A scoreboard class keeps its own
// copy of the per-event counters, sector flags, event counters and
// thresholds, and predicts the trigger decision for every end-of-event
// transaction. Each result is checked field by field against the oldest
// prediction. Phases cover disabled and maximum thresholds, simulation mode,
// out-of-range sectors, unused modes and a long output hold-off that backs
// up the input.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import smt_pkg::*;

    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam int NUM_REGS       = 5;
    localparam int HOLD_CYCLES    = 400;

    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] sector;
        logic       left_pos;
        logic       right_pos;
        logic       inner_pos;
    } hit_t;

    typedef struct {
        logic                skip_event;
        logic [CNT_BITS:0]   total_mult;
        logic [CNT_BITS-2:0] outer_mult;
        logic [CNT_BITS-1:0] inner_mult;
        logic                opposite_found;
        logic [EVT_BITS-1:0] events_seen;
        logic [EVT_BITS-1:0] events_rejected;
    } decision_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_pattern_e;

    class trigger_tally;
        t_cfg                cfg;
        logic [1:0]          outer_ends [NUM_SECTORS];
        logic                inner_seen [NUM_SECTORS];
        logic [CNT_BITS-1:0] outer_total;
        logic [CNT_BITS-1:0] inner_total;
        logic [EVT_BITS-1:0] seen_count;
        logic [EVT_BITS-1:0] rejected_count;
        decision_t           decisions_due [$];
        int                  errors;
        int                  printed;

        function new();
            cfg            = '0;
            seen_count     = '0;
            rejected_count = '0;
            errors         = 0;
            printed        = 0;
            clear_event();
        endfunction

        function void clear_event();
            foreach (outer_ends[s]) begin
                outer_ends[s] = '0;
                inner_seen[s] = 1'b0;
            end
            outer_total = '0;
            inner_total = '0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_BITS-1:0] data);
            case (idx)
                CFG_MIN_TOTAL: cfg.min_total = data;
                CFG_MIN_INNER: cfg.min_inner = data;
                CFG_MIN_OUTER: cfg.min_outer = data;
                CFG_NEED_OPP:  cfg.need_opp  = data[0];
                CFG_SIM_MODE:  cfg.sim_mode  = data[0];
                default: ;
            endcase
        endfunction

        function logic [CNT_BITS-1:0] sat_inc(logic [CNT_BITS-1:0] v);
            return (v == CNT_MAX) ? v : v + 1'b1;
        endfunction

        function void add_outer_end(logic [2:0] sec);
            if (sec < NUM_SECTORS && outer_ends[sec] < 2)
                outer_ends[sec]++;
            outer_total = sat_inc(outer_total);
        endfunction

        function bit sector_active(int s);
            return outer_ends[s] >= 2 || inner_seen[s];
        endfunction

        // notes one accepted transaction, queues a decision on end of event
        function void count_item(hit_t h);
            decision_t d;
            case (h.mode)
                MODE_OUTER: begin
                    if (h.right_pos)
                        add_outer_end(h.sector);
                    if (h.left_pos)
                        add_outer_end(h.sector);
                end
                MODE_INNER: begin
                    if (cfg.sim_mode || h.inner_pos) begin
                        if (h.sector < NUM_SECTORS)
                            inner_seen[h.sector] = 1'b1;
                        inner_total = sat_inc(inner_total);
                    end
                end
                MODE_EOE: begin
                    d.outer_mult     = outer_total[CNT_BITS-1:1];
                    d.inner_mult     = inner_total;
                    d.total_mult     = d.outer_mult + d.inner_mult;
                    d.opposite_found = (sector_active(0) && sector_active(3)) ||
                                       (sector_active(1) && sector_active(4)) ||
                                       (sector_active(2) && sector_active(5));
                    d.skip_event     = d.total_mult < cfg.min_total ||
                                       d.inner_mult < cfg.min_inner ||
                                       d.outer_mult < cfg.min_outer ||
                                       (cfg.need_opp && !d.opposite_found);
                    seen_count++;
                    if (d.skip_event)
                        rejected_count++;
                    d.events_seen     = seen_count;
                    d.events_rejected = rejected_count;
                    decisions_due.push_back(d);
                    clear_event();
                end
                default: ;
            endcase
        endfunction

        task report(string msg);
            errors++;
            if (printed < 50) begin
                printed++;
                $display("[%0t] mismatch: %s", $time, msg);
            end
        endtask

        task compare_field(string name, logic [EVT_BITS-1:0] got, logic [EVT_BITS-1:0] want,
                           logic [EVT_BITS-1:0] evt);
            if (got !== want)
                report($sformatf("event %0d %s: got %0d, expected %0d", evt, name, got, want));
        endtask

        task check_decision(decision_t got);
            decision_t want;
            if (decisions_due.size() == 0) begin
                report($sformatf("result with none expected, events_seen %0d",
                                 got.events_seen));
                return;
            end
            want = decisions_due.pop_front();
            compare_field("skip_event", got.skip_event, want.skip_event, want.events_seen);
            compare_field("total_mult", got.total_mult, want.total_mult, want.events_seen);
            compare_field("outer_mult", got.outer_mult, want.outer_mult, want.events_seen);
            compare_field("inner_mult", got.inner_mult, want.inner_mult, want.events_seen);
            compare_field("opposite_found", got.opposite_found, want.opposite_found,
                          want.events_seen);
            compare_field("events_seen", got.events_seen, want.events_seen, want.events_seen);
            compare_field("events_rejected", got.events_rejected, want.events_rejected,
                          want.events_seen);
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CNT_BITS-1:0]  i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [1:0]           i_mode;
    logic [2:0]           i_sector;
    logic                 i_left_time_pos;
    logic                 i_right_time_pos;
    logic                 i_inner_time_pos;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic                 o_skip_event;
    logic [CNT_BITS:0]    o_total_mult;
    logic [CNT_BITS-2:0]  o_outer_mult;
    logic [CNT_BITS-1:0]  o_inner_mult;
    logic                 o_opposite_found;
    logic [EVT_BITS-1:0]  o_events_seen;
    logic [EVT_BITS-1:0]  o_events_rejected;

    trigger_tally sb;
    int           burst_left  = 0;
    bit           in_valid_up = 1'b0;
    bit           hold_req    = 1'b0;

    sector_multiplicity_trigger_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_mode            (i_mode),
        .i_sector          (i_sector),
        .i_left_time_pos   (i_left_time_pos),
        .i_right_time_pos  (i_right_time_pos),
        .i_inner_time_pos  (i_inner_time_pos),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_skip_event      (o_skip_event),
        .o_total_mult      (o_total_mult),
        .o_outer_mult      (o_outer_mult),
        .o_inner_mult      (o_inner_mult),
        .o_opposite_found  (o_opposite_found),
        .o_events_seen     (o_events_seen),
        .o_events_rejected (o_events_rejected)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(5_000_000);
        $display("testbench: done, errors");
        $finish;
    end

    function automatic hit_t make_hit(logic [1:0] m, int s, int l, int r, int n);
        hit_t h;
        h.mode      = m;
        h.sector    = 3'(s);
        h.left_pos  = 1'(l);
        h.right_pos = 1'(r);
        h.inner_pos = 1'(n);
        return h;
    endfunction

    function automatic hit_t random_hit();
        hit_t h;
        h.mode      = $urandom_range(0, 1) ? MODE_INNER : MODE_OUTER;
        h.sector    = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                                  : 3'($urandom_range(0, 5));
        h.left_pos  = ($urandom_range(0, 3) != 0);
        h.right_pos = ($urandom_range(0, 3) != 0);
        h.inner_pos = ($urandom_range(0, 3) != 0);
        return h;
    endfunction

    function automatic t_cfg random_config(int top);
        t_cfg c;
        c.min_total = CNT_BITS'($urandom_range(0, top));
        c.min_inner = CNT_BITS'($urandom_range(0, top / 2));
        c.min_outer = CNT_BITS'($urandom_range(0, top / 2));
        c.need_opp  = 1'($urandom_range(0, 1));
        c.sim_mode  = 1'($urandom_range(0, 1));
        return c;
    endfunction

    task automatic lower_valid();
        if (in_valid_up) begin
            i_in_valid  <= 1'b0;
            in_valid_up = 1'b0;
        end
    endtask

    task automatic send_hit(hit_t h);
        if (burst_left == 0) begin
            lower_valid();
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 16);
        end
        i_in_valid       <= 1'b1;
        in_valid_up      = 1'b1;
        i_mode           <= h.mode;
        i_sector         <= h.sector;
        i_left_time_pos  <= h.left_pos;
        i_right_time_pos <= h.right_pos;
        i_inner_time_pos <= h.inner_pos;
        do @(posedge i_clk); while (!o_in_ready);
        sb.count_item(h);
        burst_left--;
    endtask

    task automatic drain_results();
        int guard;
        guard = 0;
        lower_valid();
        while (sb.decisions_due.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_config(t_cfg c);
        logic [CNT_BITS-1:0] vals [NUM_REGS];
        vals[CFG_MIN_TOTAL] = c.min_total;
        vals[CFG_MIN_INNER] = c.min_inner;
        vals[CFG_MIN_OUTER] = c.min_outer;
        vals[CFG_NEED_OPP]  = CNT_BITS'(c.need_opp);
        vals[CFG_SIM_MODE]  = CNT_BITS'(c.sim_mode);
        for (int i = 0; i < NUM_REGS; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(i);
            i_cfg_data <= vals[i];
            @(posedge i_clk);
            sb.set_reg(CFG_IDX_W'(i), vals[i]);
        end
        i_cfg_we <= 1'b0;
    endtask

    // well-formed events with random content, sprinkled with unused-mode noise
    task automatic run_events(int budget);
        int   sent;
        int   n_hits;
        hit_t h;
        sent = 0;
        while (sent < budget) begin
            n_hits = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40)
                                                 : $urandom_range(0, 8);
            for (int k = 0; k < n_hits; k++) begin
                if ($urandom_range(0, 19) == 0) begin
                    h      = random_hit();
                    h.mode = MODE_NONE;
                    send_hit(h);
                end
                send_hit(random_hit());
                sent++;
            end
            h      = random_hit();
            h.mode = MODE_EOE;
            send_hit(h);
            sent++;
            if ($urandom_range(0, 15) == 0)
                drain_results();
        end
    endtask

    initial begin : receiver
        rx_pattern_e pattern;
        int          pattern_left;
        int          hold_left;
        int          tick;
        decision_t   got;
        pattern      = RX_OPEN;
        pattern_left = 0;
        hold_left    = 0;
        tick         = 0;
        i_out_ready  <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                got.skip_event      = o_skip_event;
                got.total_mult      = o_total_mult;
                got.outer_mult      = o_outer_mult;
                got.inner_mult      = o_inner_mult;
                got.opposite_found  = o_opposite_found;
                got.events_seen     = o_events_seen;
                got.events_rejected = o_events_rejected;
                sb.check_decision(got);
            end
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            tick++;
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                if (pattern_left == 0) begin
                    pattern      = rx_pattern_e'($urandom_range(0, 3));
                    pattern_left = $urandom_range(8, 64);
                end
                pattern_left--;
                case (pattern)
                    RX_OPEN:   i_out_ready <= 1'b1;
                    RX_COIN:   i_out_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: i_out_ready <= (tick % 4 == 0);
                    default:   i_out_ready <= tick[0];
                endcase
            end
        end
    end

    initial begin : stimulus
        t_cfg c;
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= '0;
        i_cfg_data       <= '0;
        i_in_valid       <= 1'b0;
        i_mode           <= MODE_OUTER;
        i_sector         <= '0;
        i_left_time_pos  <= 1'b0;
        i_right_time_pos <= 1'b0;
        i_inner_time_pos <= 1'b0;
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed events under a light threshold and the opposite-pair check
        c           = '0;
        c.min_total = CNT_BITS'(1);
        c.need_opp  = 1'b1;
        load_config(c);
        send_hit(make_hit(MODE_OUTER, 0, 1, 1, 0));
        send_hit(make_hit(MODE_OUTER, 3, 1, 0, 0));
        send_hit(make_hit(MODE_OUTER, 3, 0, 1, 0));
        send_hit(make_hit(MODE_INNER, 7, 0, 0, 1));
        send_hit(make_hit(MODE_OUTER, 6, 1, 1, 0));
        send_hit(make_hit(MODE_OUTER, 7, 0, 1, 0));
        send_hit(make_hit(MODE_INNER, 5, 1, 1, 0));
        send_hit(make_hit(MODE_INNER, 2, 0, 0, 1));
        send_hit(make_hit(MODE_NONE, 7, 1, 1, 1));
        send_hit(make_hit(MODE_EOE, 0, 0, 0, 0));
        send_hit(make_hit(MODE_INNER, 1, 0, 0, 1));
        send_hit(make_hit(MODE_INNER, 4, 0, 0, 1));
        send_hit(make_hit(MODE_OUTER, 2, 0, 0, 1));
        send_hit(make_hit(MODE_OUTER, 5, 1, 0, 0));
        send_hit(make_hit(MODE_EOE, 7, 1, 1, 1));
        send_hit(make_hit(MODE_EOE, 4, 0, 1, 0));
        send_hit(make_hit(MODE_INNER, 0, 1, 0, 1));
        send_hit(make_hit(MODE_OUTER, 3, 1, 0, 1));
        send_hit(make_hit(MODE_EOE, 3, 1, 0, 1));
        drain_results();

        c.min_total = CNT_BITS'(2);
        c.min_inner = CNT_BITS'(1);
        c.min_outer = CNT_BITS'(1);
        c.need_opp  = 1'b1;
        c.sim_mode  = 1'b1;
        load_config(c);
        run_events(100);
        drain_results();

        // long output hold-off so the input backs up
        load_config(random_config(8));
        hold_req = 1'b1;
        run_events(100);
        drain_results();

        c          = '1;
        c.sim_mode = 1'b0;
        load_config(c);
        run_events(30);
        drain_results();

        load_config('0);
        run_events(60);
        drain_results();

        load_config(random_config(6));
        run_events(100);
        drain_results();
        repeat (10) @(posedge i_clk);

        while (sb.decisions_due.size() != 0) begin
            sb.report($sformatf("expected result never came, events_seen %0d",
                                sb.decisions_due[0].events_seen));
            void'(sb.decisions_due.pop_front());
        end
        if (sb.errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

/* filelist.f */
rtl/smt_pkg.sv
rtl/smt_accum.sv
rtl/smt_eval.sv
rtl/sector_multiplicity_trigger_unit.sv
dv/testbench.sv
